[hw/rtl/rpd_pkg.sv]
// rpd_pkg: shared types and constants of the radius packet deframer
// byte kind and error codes, parse phase enum, parse state and result structs
// no dependencies

package rpd_pkg;

   // header layout
   localparam logic [15:0] HEADER_LEN  = 16'd20;
   localparam logic [15:0] AUTH_LEN    = 16'd16;
   localparam logic [15:0] AUTH_START  = HEADER_LEN - AUTH_LEN;
   localparam logic [15:0] HEADER_LAST = HEADER_LEN - 16'd1;
   localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

   // byte kinds
   localparam logic [3:0] KIND_CODE     = 4'd0;
   localparam logic [3:0] KIND_IDENT    = 4'd1;
   localparam logic [3:0] KIND_LEN_HI   = 4'd2;
   localparam logic [3:0] KIND_LEN_LO   = 4'd3;
   localparam logic [3:0] KIND_AUTH     = 4'd4;
   localparam logic [3:0] KIND_ATTR_TYP = 4'd5;
   localparam logic [3:0] KIND_ATTR_LEN = 4'd6;
   localparam logic [3:0] KIND_ATTR_DAT = 4'd7;
   localparam logic [3:0] KIND_IGNORED  = 4'd8;

   // error codes
   localparam logic [1:0] ERR_NONE        = 2'd0;
   localparam logic [1:0] ERR_ATTR_SHORT  = 2'd1;
   localparam logic [1:0] ERR_ATTR_OVERRUN = 2'd2;
   localparam logic [1:0] ERR_BAD_LENGTH  = 2'd3;

   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_TYPE   = 5'b00010,
      PH_LEN    = 5'b00100,
      PH_DATA   = 5'b01000,
      PH_DONE   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [15:0] byte_pos;
      logic [15:0] pkt_len;
      phase_type   phase;
      logic [7:0]  attr_left;
      logic [7:0]  attr_cnt;
      logic [7:0]  attr_off;
      logic [1:0]  err;
   } parse_state_type;

   localparam parse_state_type STATE_CLEAR = '{
      byte_pos:  16'd0,
      pkt_len:   16'd0,
      phase:     PH_HEADER,
      attr_left: 8'd0,
      attr_cnt:  8'd0,
      attr_off:  8'd0,
      err:       ERR_NONE
   };

   typedef struct packed {
      logic [3:0]  byte_kind;
      logic [7:0]  byte_out;
      logic [7:0]  attr_index;
      logic [7:0]  field_offset;
      logic [15:0] declared_length;
      logic        last_of_packet;
      logic [1:0]  error_code;
   } result_type;

endpackage

[hw/rtl/rpd_parse_step.sv]
// rpd_parse_step: per-byte tagging logic, purely combinational
// takes current parse state and one byte, gives next state and the tagged result
// depends on rpd_pkg

module rpd_parse_step (
   input  rpd_pkg::parse_state_type state_cur,
   input  logic [7:0]               byte_value,
   input  logic                     packet_start,
   input  logic [15:0]              max_len,
   output rpd_pkg::parse_state_type state_nxt,
   output rpd_pkg::result_type      result
);

   rpd_pkg::parse_state_type cur;
   logic [16:0] pos_plus1;
   logic [16:0] len_end;
   logic        at_end;
   logic        err_byte;
   logic        finish;
   logic [1:0]  err;
   logic [15:0] new_len;
   logic [7:0]  left_dec;

   always_comb begin
      cur       = packet_start ? rpd_pkg::STATE_CLEAR : state_cur;
      state_nxt = cur;
      pos_plus1 = {1'b0, cur.byte_pos} + 17'd1;
      at_end    = pos_plus1 >= {1'b0, cur.pkt_len};
      len_end   = {1'b0, cur.byte_pos} + {9'd0, byte_value};
      err_byte  = 1'b0;
      finish    = 1'b0;
      err       = rpd_pkg::ERR_NONE;
      new_len   = {cur.pkt_len[15:8], byte_value};
      left_dec  = cur.attr_left - 8'd1;

      result.byte_kind       = rpd_pkg::KIND_IGNORED;
      result.byte_out        = byte_value;
      result.attr_index      = cur.attr_cnt;
      result.field_offset    = 8'd0;
      result.last_of_packet  = 1'b0;

      if (cur.byte_pos != 16'hFFFF) begin
         state_nxt.byte_pos = cur.byte_pos + 16'd1;
      end

      unique case (cur.phase)
         rpd_pkg::PH_HEADER: begin
            result.attr_index = 8'd0;
            if (cur.byte_pos == 16'd0) begin
               result.byte_kind = rpd_pkg::KIND_CODE;
            end else if (cur.byte_pos == 16'd1) begin
               result.byte_kind = rpd_pkg::KIND_IDENT;
            end else if (cur.byte_pos == 16'd2) begin
               result.byte_kind  = rpd_pkg::KIND_LEN_HI;
               state_nxt.pkt_len = {byte_value, 8'h00};
            end else if (cur.byte_pos == 16'd3) begin
               result.byte_kind  = rpd_pkg::KIND_LEN_LO;
               state_nxt.pkt_len = new_len;
               if (new_len < rpd_pkg::HEADER_LEN || new_len > max_len) begin
                  err      = rpd_pkg::ERR_BAD_LENGTH;
                  err_byte = 1'b1;
               end
            end else begin
               result.byte_kind    = rpd_pkg::KIND_AUTH;
               result.field_offset = cur.byte_pos[7:0] - rpd_pkg::AUTH_START[7:0];
               if (cur.byte_pos >= rpd_pkg::HEADER_LAST) begin
                  if (cur.pkt_len <= rpd_pkg::HEADER_LEN) begin
                     result.last_of_packet = 1'b1;
                     state_nxt.phase       = rpd_pkg::PH_DONE;
                  end else begin
                     state_nxt.phase = rpd_pkg::PH_TYPE;
                  end
               end
            end
         end
         rpd_pkg::PH_TYPE: begin
            result.byte_kind = rpd_pkg::KIND_ATTR_TYP;
            if (at_end) begin
               err      = rpd_pkg::ERR_ATTR_OVERRUN;
               err_byte = 1'b1;
            end else begin
               state_nxt.phase = rpd_pkg::PH_LEN;
            end
         end
         rpd_pkg::PH_LEN: begin
            result.byte_kind = rpd_pkg::KIND_ATTR_LEN;
            if (byte_value < 8'd2) begin
               err      = rpd_pkg::ERR_ATTR_SHORT;
               err_byte = 1'b1;
            end else if (len_end > ({1'b0, cur.pkt_len} + 17'd1)) begin
               // attribute would end past the declared length
               err      = rpd_pkg::ERR_ATTR_OVERRUN;
               err_byte = 1'b1;
            end else if (byte_value == 8'd2) begin
               finish = 1'b1;
            end else begin
               state_nxt.attr_left = byte_value - 8'd2;
               state_nxt.attr_off  = 8'd0;
               state_nxt.phase     = rpd_pkg::PH_DATA;
            end
         end
         rpd_pkg::PH_DATA: begin
            result.byte_kind    = rpd_pkg::KIND_ATTR_DAT;
            result.field_offset = cur.attr_off;
            state_nxt.attr_off  = cur.attr_off + 8'd1;
            state_nxt.attr_left = left_dec;
            if (left_dec == 8'd0) begin
               finish = 1'b1;
            end
         end
         default: begin
            // done, or any unused phase code
            err = cur.err;
         end
      endcase

      if (finish) begin
         if (cur.attr_cnt != 8'hFF) begin
            state_nxt.attr_cnt = cur.attr_cnt + 8'd1;
         end
         if (at_end) begin
            result.last_of_packet = 1'b1;
            state_nxt.phase       = rpd_pkg::PH_DONE;
         end else begin
            state_nxt.phase = rpd_pkg::PH_TYPE;
         end
      end

      if (err_byte) begin
         state_nxt.err         = err;
         state_nxt.phase       = rpd_pkg::PH_DONE;
         result.last_of_packet = 1'b0;
      end

      result.error_code      = err;
      result.declared_length = (cur.byte_pos >= 16'd3) ? state_nxt.pkt_len : 16'd0;
   end

endmodule

[hw/rtl/radius_packet_deframer.sv]
// radius_packet_deframer: top level, request/response registers and parse state
// tags each received radius packet byte with its role in the packet
// depends on rpd_pkg and rpd_parse_step
//
// usage
//   request channel (req_): one packet byte per request, with req_packet_start
//   high on the code byte of each new packet; a stream that never raises it
//   is parsed as one packet starting at the first byte after reset
//   response channel (rsp_): one tagged byte per request, in order: byte kind,
//   byte value, attribute number, offset in authenticator or attribute data,
//   declared length, end-of-packet flag and error code
//   csr_wr_en / csr_wr_data: writes max_packet_length (reset 4096), meant to be
//   changed only while no request is in flight
// timing
//   a taken request is held in the request register, parsed, and written to
//   the response register, which drives the response channel; one request per
//   cycle sustained while rsp_ready is high; the per-byte parse is one pass of
//   logic between the request register and the response register
// reset and stalls
//   synchronous reset empties both registers and clears the parse state
//   while rsp_ready is low the response holds; one more request is absorbed
//   into the request register, then req_ready drops until the response drains

module radius_packet_deframer (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_value,
   input  logic        req_packet_start,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_byte_kind,
   output logic [7:0]  rsp_byte_out,
   output logic [7:0]  rsp_attr_index,
   output logic [7:0]  rsp_field_offset,
   output logic [15:0] rsp_declared_length,
   output logic        rsp_last_of_packet,
   output logic [1:0]  rsp_error_code,
   // configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   // request register
   logic        req_valid_ff;
   logic [7:0]  req_byte_ff;
   logic        req_start_ff;

   // response register
   logic                rsp_valid_ff;
   rpd_pkg::result_type rsp_ff;
   rpd_pkg::result_type rsp_in;

   // parse state and configuration
   rpd_pkg::parse_state_type state_ff;
   rpd_pkg::parse_state_type state_in;
   logic [15:0]              max_len_ff;

   logic req_take;
   logic advance;

   // the request register moves on when the response register is empty or draining
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   rpd_parse_step u_step (
      .state_cur    (state_ff),
      .byte_value   (req_byte_ff),
      .packet_start (req_start_ff),
      .max_len      (max_len_ff),
      .state_nxt    (state_in),
      .result       (rsp_in)
   );

   // control and parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= rpd_pkg::STATE_CLEAR;
         max_len_ff   <= rpd_pkg::MAX_LEN_RESET;
      end else begin
         if (req_take) begin
            req_valid_ff <= 1'b1;
         end else if (advance) begin
            req_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_byte_ff  <= req_byte_value;
         req_start_ff <= req_packet_start;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_byte_kind       = rsp_ff.byte_kind;
   assign rsp_byte_out        = rsp_ff.byte_out;
   assign rsp_attr_index      = rsp_ff.attr_index;
   assign rsp_field_offset    = rsp_ff.field_offset;
   assign rsp_declared_length = rsp_ff.declared_length;
   assign rsp_last_of_packet  = rsp_ff.last_of_packet;
   assign rsp_error_code      = rsp_ff.error_code;

   // a latched error always parks the parser in the done phase
   assert property (@(posedge clock) disable iff (reset)
      state_ff.err != rpd_pkg::ERR_NONE |-> state_ff.phase == rpd_pkg::PH_DONE)
      else $error("latched error outside done phase");

   // attribute phases only follow a complete header
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == rpd_pkg::PH_TYPE || state_ff.phase == rpd_pkg::PH_LEN ||
       state_ff.phase == rpd_pkg::PH_DATA) |-> state_ff.byte_pos >= rpd_pkg::HEADER_LEN)
      else $error("attribute phase inside header");

   // an error byte never closes a packet
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.byte_kind != rpd_pkg::KIND_IGNORED &&
      rsp_ff.error_code != rpd_pkg::ERR_NONE |-> !rsp_ff.last_of_packet)
      else $error("end of packet flagged on error byte");

   // ignored bytes carry no offset and no end flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.byte_kind == rpd_pkg::KIND_IGNORED
      |-> !rsp_ff.last_of_packet && rsp_ff.field_offset == 8'd0)
      else $error("ignored byte with offset or end flag");

   // a clean length byte implies a declared length of at least a header
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.byte_kind == rpd_pkg::KIND_LEN_LO &&
      rsp_ff.error_code == rpd_pkg::ERR_NONE |-> rsp_ff.declared_length >= rpd_pkg::HEADER_LEN)
      else $error("short declared length passed without error");

endmodule
